FILE: hdl/first_fit_partition_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the partition allocator
// Shared concurrent checks written through simple wrappers.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH

// check an implication on every clock edge outside reset
`define FFPA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// check an implication in the next cycle
`define FFPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Types, sizes and codes shared by the partition allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int FREE_ENTRIES  = 16;
    localparam int STACK_ENTRIES = 16;
    localparam int FREE_IDX_W    = $clog2(FREE_ENTRIES);
    localparam int STACK_IDX_W   = $clog2(STACK_ENTRIES);
    localparam int FREE_CNT_W    = $clog2(FREE_ENTRIES + 1);
    localparam int STACK_CNT_W   = $clog2(STACK_ENTRIES + 1);
    localparam int NUM_CLASSES   = 5;
    localparam int CLS_IDX_W     = 3;

    localparam int SIZE_W = 13;
    localparam int ADDR_W = 32;
    localparam int REQ_W  = 16;
    localparam int STAT_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CLASS_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_E = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 3'd6;

    localparam logic [SIZE_W-1:0] CLASS_RESET [NUM_CLASSES] =
        '{13'd32, 13'd64, 13'd128, 13'd256, 13'd512};
    localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET = 32'd65536;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_TOO_LARGE  = 3'd1,
        ST_EXHAUSTED  = 3'd2,
        ST_NOTHING    = 3'd3,
        ST_FREE_FULL  = 3'd4,
        ST_STACK_FULL = 3'd5
    } status_t;

    typedef struct packed {
        logic              op;
        logic [REQ_W-1:0]  request_size;
    } in_beat_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] chunk_address;
        logic [SIZE_W-1:0] chunk_bytes;
        logic [REQ_W-1:0]  used_size;
        logic              reused;
    } out_beat_t;

    // scan request and answer between sequencer and free table
    typedef struct packed {
        logic              start;
        logic [SIZE_W-1:0] need;
    } scan_req_t;

    typedef struct packed {
        logic                  done;
        logic                  hit;
        logic [ADDR_W-1:0]     addr;
        logic [SIZE_W-1:0]     size;
        logic [FREE_CNT_W-1:0] count;
    } scan_rsp_t;

endpackage

FILE: hdl/ffpa_if.sv
// ----------------------------------------------------------------------------
// ffpa_if
// Valid/ready channel carrying one beat of a given payload type.
// ----------------------------------------------------------------------------
interface ffpa_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/ffpa_free_table.sv
// ----------------------------------------------------------------------------
// ffpa_free_table
// Free chunk table: newest-first scan, each entry read then compared through
// one compare unit, then compaction one entry per cycle; push on free.
// ----------------------------------------------------------------------------
module ffpa_free_table
    import ffpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  scan_req_t         scan_req,
    output scan_rsp_t         scan_rsp,
    input  logic              push,
    input  logic [ADDR_W-1:0] push_addr,
    input  logic [SIZE_W-1:0] push_size
);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_CMP, S_SHIFT} tstate_t;

    logic [ADDR_W-1:0] addr_mem [FREE_ENTRIES];
    logic [SIZE_W-1:0] size_mem [FREE_ENTRIES];

    tstate_t               state_reg;
    logic [FREE_CNT_W-1:0] count_reg;
    logic [FREE_CNT_W-1:0] ptr_reg;
    logic [SIZE_W-1:0]     need_reg;
    logic [ADDR_W-1:0]     rd_addr_reg;
    logic [SIZE_W-1:0]     rd_size_reg;
    logic                  done_reg;
    logic                  hit_reg;
    logic [FREE_CNT_W-1:0] ptr_next;

    assign ptr_next = ptr_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            addr_mem[count_reg[FREE_IDX_W-1:0]] <= push_addr;
            size_mem[count_reg[FREE_IDX_W-1:0]] <= push_size;
        end
        else if (state_reg == S_SHIFT && ptr_next < count_reg)
        begin
            addr_mem[ptr_reg[FREE_IDX_W-1:0]] <= addr_mem[ptr_next[FREE_IDX_W-1:0]];
            size_mem[ptr_reg[FREE_IDX_W-1:0]] <= size_mem[ptr_next[FREE_IDX_W-1:0]];
        end
        if (state_reg == S_READ)
        begin
            rd_addr_reg <= addr_mem[ptr_reg[FREE_IDX_W-1:0]];
            rd_size_reg <= size_mem[ptr_reg[FREE_IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            need_reg  <= '0;
            done_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (push)
            begin
                count_reg <= count_reg + 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (scan_req.start)
                    begin
                        need_reg <= scan_req.need;
                        if (count_reg == '0)
                        begin
                            hit_reg  <= 1'b0;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            ptr_reg   <= count_reg - 1'b1;
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (rd_size_reg >= need_reg)
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= S_SHIFT;
                    end
                    else if (ptr_reg == '0)
                    begin
                        hit_reg   <= 1'b0;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg - 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_SHIFT:
                begin
                    if (ptr_next < count_reg)
                    begin
                        ptr_reg <= ptr_next;
                    end
                    else
                    begin
                        count_reg <= count_reg - 1'b1;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign scan_rsp.done  = done_reg;
    assign scan_rsp.hit   = hit_reg;
    assign scan_rsp.addr  = rd_addr_reg;
    assign scan_rsp.size  = rd_size_reg;
    assign scan_rsp.count = count_reg;

endmodule

FILE: hdl/first_fit_partition_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_partition_allocator
// Class-rounded first-fit allocator with a grant stack and a free table.
// ----------------------------------------------------------------------------
// Input channel in_ch carries op and request_size; output channel out_ch
// carries one result beat per input beat. Configuration writes use
// cfg_we, cfg_index and cfg_data while the block is idle.
// An allocate steps one class compare per cycle (up to five), then the free
// table is scanned newest first, each entry read and then compared through
// one compare unit, and a hit is compacted one entry per cycle. A miss does
// one heap add and compare.
// One item is in flight at a time; in_ch.ready is low from acceptance until
// the cycle after the result beat has been taken, so a stalled receiver
// holds the result and blocks new input.
// Reset empties the free table and stack, restores the class sizes to
// 32/64/128/256/512, heap_limit to 65536 and the heap top to heap_base (0).
// Writing heap_base reloads the heap top.
module first_fit_partition_allocator
    import ffpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ffpa_if.sink                  in_ch,
    ffpa_if.source                out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "first_fit_partition_allocator_assert.svh"

    typedef enum logic [2:0] {S_IDLE, S_CLASS, S_SCAN, S_HEAP, S_FREE, S_OUT} state_t;

    logic [SIZE_W-1:0] class_reg [NUM_CLASSES];
    logic [ADDR_W-1:0] heap_limit_reg;
    logic [ADDR_W:0]   heap_top_reg;

    logic [ADDR_W-1:0] stk_addr_mem [STACK_ENTRIES];
    logic [SIZE_W-1:0] stk_size_mem [STACK_ENTRIES];
    logic [REQ_W-1:0]  stk_used_mem [STACK_ENTRIES];
    logic [STACK_CNT_W-1:0] stk_count_reg;

    state_t            state_reg;
    logic [CLS_IDX_W-1:0] cls_idx_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [SIZE_W-1:0] cls_reg;
    out_beat_t         out_reg;
    logic              ft_push_reg;
    logic              stk_push;
    logic              stk_pop_rd;

    scan_req_t scan_req;
    scan_rsp_t scan_rsp;
    logic              ft_push;
    logic [ADDR_W-1:0] ft_push_addr;
    logic [SIZE_W-1:0] ft_push_size;

    logic [ADDR_W:0]   heap_sum;
    logic [STACK_IDX_W-1:0] stk_top;

    function automatic out_beat_t err_beat(status_t st);
        out_beat_t b;
        b = '0;
        b.status = st;
        return b;
    endfunction

    assign heap_sum = heap_top_reg + {{(ADDR_W + 1 - SIZE_W){1'b0}}, cls_reg};
    assign stk_top  = stk_count_reg[STACK_IDX_W-1:0] - 1'b1;

    ffpa_free_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .scan_req  (scan_req),
        .scan_rsp  (scan_rsp),
        .push      (ft_push),
        .push_addr (ft_push_addr),
        .push_size (ft_push_size)
    );

    assign scan_req.start = (state_reg == S_CLASS) && (cls_idx_reg < CLS_IDX_W'(NUM_CLASSES))
        && ({3'b0, class_reg[cls_idx_reg]} >= req_reg)
        && (stk_count_reg < STACK_CNT_W'(STACK_ENTRIES));
    assign scan_req.need  = class_reg[cls_idx_reg];
    assign ft_push      = ft_push_reg;
    assign ft_push_addr = out_reg.chunk_address;
    assign ft_push_size = out_reg.chunk_bytes;
    assign stk_push   = (state_reg == S_SCAN && scan_rsp.done && scan_rsp.hit)
        || (state_reg == S_HEAP && heap_sum <= {1'b0, heap_limit_reg});
    assign stk_pop_rd = 1'b0;

    always_ff @(posedge clk)
    begin
        if (stk_push)
        begin
            stk_addr_mem[stk_count_reg[STACK_IDX_W-1:0]] <=
                (state_reg == S_SCAN) ? scan_rsp.addr : heap_top_reg[ADDR_W-1:0];
            stk_size_mem[stk_count_reg[STACK_IDX_W-1:0]] <=
                (state_reg == S_SCAN) ? scan_rsp.size : cls_reg;
            stk_used_mem[stk_count_reg[STACK_IDX_W-1:0]] <= req_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                class_reg[k] <= CLASS_RESET[k];
            end
            heap_limit_reg <= HEAP_LIMIT_RESET;
            heap_top_reg   <= '0;
            stk_count_reg  <= '0;
            cls_idx_reg    <= '0;
            req_reg        <= '0;
            cls_reg        <= '0;
            out_reg        <= '0;
            ft_push_reg    <= 1'b0;
        end
        else
        begin
            ft_push_reg <= (state_reg == S_FREE);
            if (cfg_we)
            begin
                if (cfg_index <= REG_CLASS_E)
                begin
                    class_reg[cfg_index - REG_CLASS_A] <= cfg_data[SIZE_W-1:0];
                end
                else if (cfg_index == REG_HEAP_BASE)
                begin
                    heap_top_reg  <= {1'b0, cfg_data};
                end
                else if (cfg_index == REG_HEAP_LIMIT)
                begin
                    heap_limit_reg <= cfg_data;
                end
            end
            if (stk_push)
            begin
                stk_count_reg <= stk_count_reg + 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        req_reg     <= in_ch.data.request_size;
                        cls_idx_reg <= '0;
                        if (in_ch.data.op)
                        begin
                            if (stk_count_reg == '0)
                            begin
                                out_reg   <= err_beat(ST_NOTHING);
                                state_reg <= S_OUT;
                            end
                            else if (scan_rsp.count >= FREE_CNT_W'(FREE_ENTRIES))
                            begin
                                out_reg   <= err_beat(ST_FREE_FULL);
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                out_reg   <= '0;
                                state_reg <= S_FREE;
                            end
                        end
                        else
                        begin
                            out_reg   <= '0;
                            state_reg <= S_CLASS;
                        end
                    end
                end
                S_CLASS:
                begin
                    if (cls_idx_reg >= CLS_IDX_W'(NUM_CLASSES))
                    begin
                        out_reg.status <= ST_TOO_LARGE;
                        state_reg      <= S_OUT;
                    end
                    else if ({3'b0, class_reg[cls_idx_reg]} >= req_reg)
                    begin
                        cls_reg <= class_reg[cls_idx_reg];
                        if (stk_count_reg >= STACK_CNT_W'(STACK_ENTRIES))
                        begin
                            out_reg.status <= ST_STACK_FULL;
                            state_reg      <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                    else
                    begin
                        cls_idx_reg <= cls_idx_reg + 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (scan_rsp.done)
                    begin
                        if (scan_rsp.hit)
                        begin
                            out_reg.status        <= ST_OK;
                            out_reg.chunk_address <= scan_rsp.addr;
                            out_reg.chunk_bytes   <= scan_rsp.size;
                            out_reg.used_size     <= req_reg;
                            out_reg.reused        <= 1'b1;
                            state_reg             <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_HEAP;
                        end
                    end
                end
                S_HEAP:
                begin
                    if (heap_sum <= {1'b0, heap_limit_reg})
                    begin
                        out_reg.status        <= ST_OK;
                        out_reg.chunk_address <= heap_top_reg[ADDR_W-1:0];
                        out_reg.chunk_bytes   <= cls_reg;
                        out_reg.used_size     <= req_reg;
                        heap_top_reg          <= heap_sum;
                    end
                    else
                    begin
                        out_reg.status <= ST_EXHAUSTED;
                    end
                    state_reg <= S_OUT;
                end
                S_FREE:
                begin
                    out_reg.status        <= ST_OK;
                    out_reg.chunk_address <= stk_addr_mem[stk_top];
                    out_reg.chunk_bytes   <= stk_size_mem[stk_top];
                    out_reg.used_size     <= stk_used_mem[stk_top];
                    stk_count_reg         <= stk_count_reg - 1'b1;
                    state_reg             <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ch.ready  = (state_reg == S_IDLE) && !stk_pop_rd;
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.data  = out_reg;

    `FFPA_ASSERT_IMPL(a_stack_bound, 1'b1, stk_count_reg <= STACK_CNT_W'(STACK_ENTRIES))
    `FFPA_ASSERT_IMPL(a_err_zero, out_ch.valid && out_reg.status != ST_OK,
        out_reg.chunk_address == '0 && out_reg.reused == 1'b0)
    `FFPA_ASSERT_NEXT(a_hold_out, out_ch.valid && !out_ch.ready,
        out_ch.valid && $stable(out_reg))
    `FFPA_ASSERT_IMPL(a_busy_block, state_reg != S_IDLE, !in_ch.ready)

endmodule
